/* rtl/fz_pkg.sv */
// Package for the two-input fuzzy controller.
// Holds payload types, the membership shape record and register indexes.
// No dependencies.
package fz_pkg;

   localparam int DATA_W = 16;
   localparam int MEM_W  = 16;
   localparam int PROD_W = 32;
   localparam int SUM_W  = 33;
   localparam int WR_W   = 33;
   localparam int NUM_W  = 35;
   localparam int MAG_W  = 33;
   localparam int DEN_W  = 18;
   localparam int Q_W    = 16;
   localparam int ADDR_W = 6;
   localparam int CSR_W  = 64;

   localparam logic [MEM_W-1:0] MEM_ONE = 16'h8000;

   localparam logic [2:0] REG_UPPER    = 3'd0;
   localparam logic [2:0] REG_LOWER    = 3'd1;
   localparam logic [2:0] REG_RSLOPE   = 3'd2;
   localparam logic [2:0] REG_ROFFSET  = 3'd3;
   localparam logic [2:0] REG_FSLOPE   = 3'd4;
   localparam logic [2:0] REG_FOFFSET  = 3'd5;
   localparam logic [2:0] REG_RULES    = 3'd6;

   typedef struct packed {
      logic signed [DATA_W-1:0] error_value;
      logic signed [DATA_W-1:0] error_change;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive_value;
      logic                     zero_weight;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] upper_bound;
      logic signed [DATA_W-1:0] lower_bound;
      logic signed [DATA_W-1:0] rise_slope;
      logic signed [DATA_W-1:0] rise_offset;
      logic signed [DATA_W-1:0] fall_slope;
      logic signed [DATA_W-1:0] fall_offset;
   } shape_type;

endpackage

/* rtl/fz_grade.sv */
// Two-stage membership grading of one input: rising and falling grades.
// Depends on fz_pkg.
module fz_grade
   import fz_pkg::*;
(
   input  logic                     clock,
   input  logic signed [DATA_W-1:0] x,
   input  shape_type                shape,
   output logic        [MEM_W-1:0]  rise,
   output logic        [MEM_W-1:0]  fall
);

   logic signed [PROD_W-1:0] rprod_ff, rprod_in, fprod_ff, fprod_in;
   logic                     gt_ff, gt_in, lt_ff, lt_in;
   logic        [MEM_W-1:0]  rise_ff, rise_in, fall_ff, fall_in;

   function automatic logic [MEM_W-1:0] lin_grade(input logic signed [PROD_W-1:0] prod,
                                                  input logic signed [DATA_W-1:0] off);
      logic signed [SUM_W-1:0] sum;
      begin
         sum = {prod[PROD_W-1], prod} + {{5{off[DATA_W-1]}}, off, 12'b0};
         if (sum <= 0)
            lin_grade = '0;
         else if (sum >= (SUM_W'(1) <<< 24))
            lin_grade = MEM_ONE;
         else
            lin_grade = {1'b0, sum[23:9]};
      end
   endfunction

   always_comb begin
      rprod_in = PROD_W'(shape.rise_slope) * PROD_W'(x);
      fprod_in = PROD_W'(shape.fall_slope) * PROD_W'(x);
      gt_in    = x > shape.upper_bound;
      lt_in    = x < shape.lower_bound;
   end

   always_comb begin
      if (gt_ff) begin
         rise_in = MEM_ONE;
         fall_in = '0;
      end else if (lt_ff) begin
         rise_in = '0;
         fall_in = MEM_ONE;
      end else begin
         rise_in = lin_grade(rprod_ff, shape.rise_offset);
         fall_in = lin_grade(fprod_ff, shape.fall_offset);
      end
   end

   always_ff @(posedge clock) begin
      rprod_ff <= rprod_in;
      fprod_ff <= fprod_in;
      gt_ff    <= gt_in;
      lt_ff    <= lt_in;
      rise_ff  <= rise_in;
      fall_ff  <= fall_in;
   end

   assign rise = rise_ff;
   assign fall = fall_ff;

endmodule

/* rtl/fz_div.sv */
// Pipelined restoring divider, one quotient bit per stage, sign and zero fixup.
// Depends on fz_pkg.
module fz_div
   import fz_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [MAG_W-1:0] mag,
   input  logic [DEN_W-1:0] den,
   input  logic             neg,
   input  logic             zero,
   output logic             out_valid,
   output rsp_type          result
);

   logic [MAG_W-1:0] rem_ff  [1:Q_W];
   logic [DEN_W-1:0] den_ff  [1:Q_W];
   logic [Q_W-1:0]   q_ff    [1:Q_W];
   logic             neg_ff  [1:Q_W];
   logic             zero_ff [1:Q_W];
   logic             v_ff    [1:Q_W];

   logic [MAG_W-1:0] rem_cur [0:Q_W-1];
   logic [DEN_W-1:0] den_cur [0:Q_W-1];
   logic [Q_W-1:0]   q_cur   [0:Q_W-1];
   logic             neg_cur [0:Q_W-1];
   logic             zero_cur[0:Q_W-1];
   logic             v_cur   [0:Q_W-1];
   logic [MAG_W-1:0] rem_in  [0:Q_W-1];
   logic [Q_W-1:0]   q_in    [0:Q_W-1];

   rsp_type          rsp_ff, rsp_in;
   logic             valid_ff;
   logic [Q_W-1:0]   qneg;

   always_comb begin
      rem_cur[0]  = mag;
      den_cur[0]  = den;
      q_cur[0]    = '0;
      neg_cur[0]  = neg;
      zero_cur[0] = zero;
      v_cur[0]    = in_valid;
      for (int j = 1; j < Q_W; j++) begin
         rem_cur[j]  = rem_ff[j];
         den_cur[j]  = den_ff[j];
         q_cur[j]    = q_ff[j];
         neg_cur[j]  = neg_ff[j];
         zero_cur[j] = zero_ff[j];
         v_cur[j]    = v_ff[j];
      end
   end

   always_comb begin
      for (int j = 0; j < Q_W; j++) begin
         logic [MAG_W:0] dsh;
         logic [MAG_W:0] diff;
         dsh  = {{(MAG_W+1-DEN_W){1'b0}}, den_cur[j]} << (Q_W - 1 - j);
         diff = {1'b0, rem_cur[j]} - dsh;
         if (!diff[MAG_W]) begin
            rem_in[j] = diff[MAG_W-1:0];
            q_in[j]   = {q_cur[j][Q_W-2:0], 1'b1};
         end else begin
            rem_in[j] = rem_cur[j];
            q_in[j]   = {q_cur[j][Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < Q_W; j++) begin
         rem_ff[j+1]  <= rem_in[j];
         den_ff[j+1]  <= den_cur[j];
         q_ff[j+1]    <= q_in[j];
         neg_ff[j+1]  <= neg_cur[j];
         zero_ff[j+1] <= zero_cur[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 1; j <= Q_W; j++) v_ff[j] <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         for (int j = 0; j < Q_W; j++) v_ff[j+1] <= v_cur[j];
         valid_ff <= v_ff[Q_W];
      end
   end

   always_comb begin
      qneg = -q_ff[Q_W];
      rsp_in.zero_weight = zero_ff[Q_W];
      if (zero_ff[Q_W])
         rsp_in.drive_value = '0;
      else if (neg_ff[Q_W])
         rsp_in.drive_value = qneg;
      else
         rsp_in.drive_value = q_ff[Q_W];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign result    = rsp_ff;

endmodule

/* rtl/fuzzy_two_input_controller_top.sv */
// Two-input Sugeno fuzzy PD controller, top level.
// Depends on fz_pkg, fz_grade, fz_div.
//
// Usage:
//   Drive req_payload (error_value, error_change) with start high; an item is
//   taken at each edge where start is high and busy is low. busy stays low,
//   so an item may enter every cycle.
//   Each result appears on rsp_payload with rsp_valid high for one cycle,
//   after its item has passed the input register, membership grading,
//   rule weighting and products, accumulation, the pipelined divider
//   (one quotient bit per stage) and the output register.
//   Throughput is one item per cycle, set by the fully pipelined divider.
//   The receiver cannot stall; results are never held.
//   Registers sit on an APB-style port at byte address 8*index, 64-bit data.
//   Write registers only while no item is in flight.
//   Reset clears all valid bits and loads the register defaults; items in
//   flight are dropped.
module fuzzy_two_input_controller_top
   import fz_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_payload,
   output logic              rsp_valid,
   output rsp_type           rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [CSR_W-1:0]  pwdata,
   output logic [CSR_W-1:0]  prdata,
   output logic              pready
);

   shape_type               shape_ff;
   logic [CSR_W-1:0]        rules_ff;
   logic                    wr_en;
   logic [2:0]              reg_idx;

   req_type                 req_ff;
   logic                    v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;

   logic [MEM_W-1:0]        re, fe, rc, fc;
   logic [MEM_W-1:0]        w     [0:3];
   logic signed [WR_W-1:0]  wr_ff [0:3];
   logic signed [WR_W-1:0]  wr_in [0:3];
   logic [DEN_W-1:0]        den_ff, den_in;

   logic signed [NUM_W-1:0] num;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [DEN_W-1:0]        den4_ff;
   logic                    neg_ff, zero_ff;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[5:3];
   assign pready  = 1'b1;
   assign busy    = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff.upper_bound <= 16'sd4096;
         shape_ff.lower_bound <= -16'sd4096;
         shape_ff.rise_slope  <= 16'sd2048;
         shape_ff.rise_offset <= 16'sd2048;
         shape_ff.fall_slope  <= -16'sd2048;
         shape_ff.fall_offset <= 16'sd2048;
         rules_ff             <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_UPPER:   shape_ff.upper_bound <= pwdata[DATA_W-1:0];
            REG_LOWER:   shape_ff.lower_bound <= pwdata[DATA_W-1:0];
            REG_RSLOPE:  shape_ff.rise_slope  <= pwdata[DATA_W-1:0];
            REG_ROFFSET: shape_ff.rise_offset <= pwdata[DATA_W-1:0];
            REG_FSLOPE:  shape_ff.fall_slope  <= pwdata[DATA_W-1:0];
            REG_FOFFSET: shape_ff.fall_offset <= pwdata[DATA_W-1:0];
            REG_RULES:   rules_ff             <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_UPPER:   prdata = {48'b0, shape_ff.upper_bound};
         REG_LOWER:   prdata = {48'b0, shape_ff.lower_bound};
         REG_RSLOPE:  prdata = {48'b0, shape_ff.rise_slope};
         REG_ROFFSET: prdata = {48'b0, shape_ff.rise_offset};
         REG_FSLOPE:  prdata = {48'b0, shape_ff.fall_slope};
         REG_FOFFSET: prdata = {48'b0, shape_ff.fall_offset};
         REG_RULES:   prdata = rules_ff;
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_payload;
   end

   fz_grade u_grade_e (
      .clock (clock),
      .x     (req_ff.error_value),
      .shape (shape_ff),
      .rise  (re),
      .fall  (fe)
   );

   fz_grade u_grade_ce (
      .clock (clock),
      .x     (req_ff.error_change),
      .shape (shape_ff),
      .rise  (rc),
      .fall  (fc)
   );

   always_comb begin
      w[0] = (re < rc) ? re : rc;
      w[1] = (re < fc) ? re : fc;
      w[2] = (fe < rc) ? fe : rc;
      w[3] = (fe < fc) ? fe : fc;
      for (int k = 0; k < 4; k++) begin
         wr_in[k] = WR_W'($signed({1'b0, w[k]})) * WR_W'($signed(rules_ff[16*k +: 16]));
      end
      den_in = DEN_W'(w[0]) + DEN_W'(w[1]) + DEN_W'(w[2]) + DEN_W'(w[3]);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) wr_ff[k] <= wr_in[k];
      den_ff <= den_in;
   end

   always_comb begin
      num = NUM_W'(wr_ff[0]) + NUM_W'(wr_ff[1]) + NUM_W'(wr_ff[2]) + NUM_W'(wr_ff[3]);
      if (num[NUM_W-1])
         mag_in = MAG_W'(-num);
      else
         mag_in = MAG_W'(num);
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= num[NUM_W-1];
      den4_ff <= den_ff;
      zero_ff <= (den_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   fz_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .mag       (mag_ff),
      .den       (den4_ff),
      .neg       (neg_ff),
      .zero      (zero_ff),
      .out_valid (rsp_valid),
      .result    (rsp_payload)
   );

   a_zero_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.zero_weight |-> rsp_payload.drive_value == '0)
      else $error("zero weight result with nonzero drive");

   a_grade_range: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> re <= MEM_ONE && fe <= MEM_ONE && rc <= MEM_ONE && fc <= MEM_ONE)
      else $error("membership grade above one");

   a_den_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> den_ff <= DEN_W'(4 * 32768))
      else $error("weight sum out of range");

   a_zero_track: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> zero_ff == (den4_ff == '0))
      else $error("zero flag disagrees with weight sum");

endmodule
